// File: hw/rtl/sfc_pkg.sv
// Package for the SPI NOR flash command sequencer: payload structs, codes,
// phase and operation types, and result builder functions.
// No dependencies; imported by the sequencer and its checker.
`default_nettype none

package sfc_pkg;

    localparam int DEF_ADDRESS_BITS = 24;
    localparam int DEF_SECTOR_BYTES = 4096;

    // Page size sets the program chunk split; it must be a power of two.
    localparam int PAGE_BYTES  = 256;
    localparam int PAGE_IDX_W  = $clog2(PAGE_BYTES);
    localparam int PAGE_CNT_W  = PAGE_IDX_W + 1;

    localparam int LEN_W       = 25;
    localparam int SECTOR_W    = 12;
    localparam int BYTE_W      = 8;
    localparam int LINK_ADDR_W = 24;

    localparam logic [LEN_W-1:0]  MAX_LEN    = 25'h100_0000;
    localparam logic [BYTE_W-1:0] FILL_BYTE  = 8'hFF;
    localparam int                BUSY_BIT   = 0;
    localparam int                WEL_BIT    = 1;

    // Input modes.
    localparam logic [2:0] MODE_READ    = 3'd0;
    localparam logic [2:0] MODE_PROGRAM = 3'd1;
    localparam logic [2:0] MODE_ERASE   = 3'd2;
    localparam logic [2:0] MODE_HOST    = 3'd3;
    localparam logic [2:0] MODE_LINK    = 3'd4;

    // Result kinds.
    localparam logic [1:0] KIND_FRAME    = 2'd0;
    localparam logic [1:0] KIND_READ     = 2'd1;
    localparam logic [1:0] KIND_HOST_REQ = 2'd2;
    localparam logic [1:0] KIND_DONE     = 2'd3;

    // Completion status.
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_WEL_FAIL = 2'd1;
    localparam logic [1:0] STATUS_ZERO_LEN = 2'd2;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_LINK_CHANNEL = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_READ_OP      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PROGRAM_OP   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ERASE_OP     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_WREN_OP      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_STATUS_OP    = 3'd5;

    typedef enum logic [1:0] {
        OP_READ    = 2'd0,
        OP_PROGRAM = 2'd1,
        OP_ERASE   = 2'd2
    } op_t;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_POLL_CMD  = 4'd1,
        PH_POLL_DATA = 4'd2,
        PH_WREN      = 4'd3,
        PH_WEL_CMD   = 4'd4,
        PH_WEL_DATA  = 4'd5,
        PH_OPCODE    = 4'd6,
        PH_ADDR      = 4'd7,
        PH_DUMMY     = 4'd8,
        PH_RDATA     = 4'd9,
        PH_HOST      = 4'd10,
        PH_WDATA     = 4'd11
    } phase_t;

    typedef struct packed {
        logic [2:0]          mode;
        logic [23:0]         address;
        logic [LEN_W-1:0]    length;
        logic [SECTOR_W-1:0] first_sector;
        logic [SECTOR_W-1:0] final_sector;
        logic [BYTE_W-1:0]   host_byte;
        logic [BYTE_W-1:0]   link_byte;
    } request_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [BYTE_W-1:0] tx_byte;
        logic              end_of_frame;
        logic [1:0]        channel;
        logic [BYTE_W-1:0] read_byte;
        logic [1:0]        status;
        logic              last;
    } result_t;

    function automatic result_t frame_res(input logic [BYTE_W-1:0] tx, input logic eof,
                                          input logic [1:0] ch);
        result_t r;
        r              = '0;
        r.kind         = KIND_FRAME;
        r.tx_byte      = tx;
        r.end_of_frame = eof;
        r.channel      = ch;
        return r;
    endfunction

    function automatic result_t read_res(input logic [BYTE_W-1:0] b);
        result_t r;
        r           = '0;
        r.kind      = KIND_READ;
        r.read_byte = b;
        return r;
    endfunction

    function automatic result_t host_req_res();
        result_t r;
        r      = '0;
        r.kind = KIND_HOST_REQ;
        return r;
    endfunction

    function automatic result_t done_res(input logic [1:0] st);
        result_t r;
        r        = '0;
        r.kind   = KIND_DONE;
        r.status = st;
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/spi_nor_flash_command_sequencer.sv
// SPI NOR flash command sequencer: command phase machine and a four-entry
// result queue. Depends on sfc_pkg.
//
//   channel   | signals                                   | moves
//   ----------+-------------------------------------------+-------------------------------
//   request   | request_valid, request_stall, request     | commands, host and link bytes
//   result    | result_valid, result_stall, result        | frames, read data, requests, done
//   config    | cfg_write_enable, cfg_index, cfg_data     | register writes, no wait
//
// A request's phase update and its one or two results are written into the result queue
// at the edge that takes it, so requests may follow back to back while request_stall is low.
// A read data byte causes two results, which leave the queue one at a time.
// request_stall rises when the queue has fewer than two free entries.
// rst_n clears phase, counters, queue and the registers to their defaults at once.
`default_nettype none

module spi_nor_flash_command_sequencer
    import sfc_pkg::*;
#(
    parameter int ADDRESS_BITS = DEF_ADDRESS_BITS,
    parameter int SECTOR_BYTES = DEF_SECTOR_BYTES
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   request_valid,
    output logic                        request_stall,
    input  wire request_t               request,
    output logic                        result_valid,
    input  wire logic                   result_stall,
    output result_t                     result,
    input  wire logic                   cfg_write_enable,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [BYTE_W-1:0]      cfg_data
);

    localparam int AW       = ADDRESS_BITS;
    localparam int PROD_W   = SECTOR_W + $clog2(SECTOR_BYTES + 1);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W   = QPTR_W + 1;

    // Configuration registers.
    logic [1:0]        link_channel_reg;
    logic [BYTE_W-1:0] read_op_reg, program_op_reg, erase_op_reg, wren_op_reg, status_op_reg;

    // Sequencer state.
    phase_t              phase_reg, phase_next;
    op_t                 operation_reg, operation_next;
    logic [AW-1:0]       cur_addr_reg, cur_addr_next;
    logic [LEN_W-1:0]    bytes_left_reg, bytes_left_next;
    logic [PAGE_CNT_W-1:0] page_left_reg, page_left_next;
    logic [SECTOR_W-1:0] cur_sector_reg, cur_sector_next;
    logic [SECTOR_W-1:0] stop_sector_reg, stop_sector_next;
    logic [1:0]          addr_idx_reg, addr_idx_next;

    // Result queue.
    result_t             queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   rd_ptr_reg, wr_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;

    logic                accept, pop;
    logic [1:0]          push_cnt;
    result_t             res0, res1;

    logic [PROD_W-1:0]     erase_base;
    logic [AW-1:0]         op_addr;
    logic [LINK_ADDR_W-1:0] link_addr;
    logic [1:0]            idx_inc;
    logic [BYTE_W-1:0]     addr_byte_next;
    logic [PAGE_CNT_W-1:0] room;
    logic [LEN_W-1:0]      len_clamped;
    logic [LEN_W-1:0]      bytes_dec;
    logic [PAGE_CNT_W-1:0] page_dec;
    logic                  link_mode;

    assign request_stall = count_reg > QCNT_W'(QUEUE_DEPTH - 2);
    assign accept        = request_valid && !request_stall;
    assign result_valid  = count_reg != '0;
    assign result        = queue_reg[rd_ptr_reg];
    assign pop           = result_valid && !result_stall;

    // Address of the command in progress; erase addresses come from the sector index.
    assign erase_base  = PROD_W'(cur_sector_reg) * PROD_W'(SECTOR_BYTES);
    assign op_addr     = (operation_reg == OP_ERASE) ? AW'(erase_base) : cur_addr_reg;
    assign link_addr   = LINK_ADDR_W'(op_addr);
    assign idx_inc     = addr_idx_reg + 2'd1;

    always_comb
    begin
        case (idx_inc)
            2'd1:    addr_byte_next = link_addr[15:8];
            default: addr_byte_next = link_addr[7:0];
        endcase
    end

    assign room      = PAGE_CNT_W'(PAGE_BYTES) - PAGE_CNT_W'(cur_addr_reg[PAGE_IDX_W-1:0]);
    assign len_clamped = (request.length > MAX_LEN) ? MAX_LEN : request.length;
    assign bytes_dec = bytes_left_reg - LEN_W'(1);
    assign page_dec  = page_left_reg - PAGE_CNT_W'(1);
    assign link_mode = request.mode == MODE_LINK;

    always_comb
    begin
        phase_next       = phase_reg;
        operation_next   = operation_reg;
        cur_addr_next    = cur_addr_reg;
        bytes_left_next  = bytes_left_reg;
        page_left_next   = page_left_reg;
        cur_sector_next  = cur_sector_reg;
        stop_sector_next = stop_sector_reg;
        addr_idx_next    = addr_idx_reg;
        push_cnt         = 2'd0;
        res0             = '0;
        res1             = '0;

        if (accept)
        begin
            if (request.mode inside {MODE_READ, MODE_PROGRAM, MODE_ERASE})
            begin
                if (phase_reg == PH_IDLE)
                begin
                    push_cnt = 2'd1;
                    operation_next = op_t'(request.mode[1:0]);
                    if (request.mode == MODE_ERASE)
                    begin
                        cur_sector_next  = request.first_sector;
                        stop_sector_next = request.final_sector;
                        if (request.first_sector > request.final_sector)
                        begin
                            res0 = done_res(STATUS_OK);
                        end
                        else
                        begin
                            res0 = frame_res(status_op_reg, 1'b0, link_channel_reg);
                            phase_next = PH_POLL_CMD;
                        end
                    end
                    else
                    begin
                        cur_addr_next   = request.address[AW-1:0];
                        bytes_left_next = len_clamped;
                        page_left_next  = '0;
                        if (len_clamped == '0)
                        begin
                            res0 = done_res(STATUS_ZERO_LEN);
                        end
                        else
                        begin
                            res0 = frame_res(status_op_reg, 1'b0, link_channel_reg);
                            phase_next = PH_POLL_CMD;
                        end
                    end
                end
            end
            else if (request.mode == MODE_HOST)
            begin
                if (phase_reg == PH_HOST)
                begin
                    push_cnt   = 2'd1;
                    res0       = frame_res(request.host_byte,
                                           page_left_reg == PAGE_CNT_W'(1), link_channel_reg);
                    phase_next = PH_WDATA;
                end
            end
            else if (link_mode)
            begin
                case (phase_reg)
                    PH_POLL_CMD:
                    begin
                        push_cnt   = 2'd1;
                        res0       = frame_res(FILL_BYTE, 1'b1, link_channel_reg);
                        phase_next = PH_POLL_DATA;
                    end
                    PH_POLL_DATA:
                    begin
                        push_cnt = 2'd1;
                        if (request.link_byte[BUSY_BIT])
                        begin
                            res0       = frame_res(status_op_reg, 1'b0, link_channel_reg);
                            phase_next = PH_POLL_CMD;
                        end
                        else if (operation_reg == OP_READ)
                        begin
                            res0       = frame_res(read_op_reg, 1'b0, link_channel_reg);
                            phase_next = PH_OPCODE;
                        end
                        else
                        begin
                            res0       = frame_res(wren_op_reg, 1'b1, link_channel_reg);
                            phase_next = PH_WREN;
                        end
                    end
                    PH_WREN:
                    begin
                        push_cnt   = 2'd1;
                        res0       = frame_res(status_op_reg, 1'b0, link_channel_reg);
                        phase_next = PH_WEL_CMD;
                    end
                    PH_WEL_CMD:
                    begin
                        push_cnt   = 2'd1;
                        res0       = frame_res(FILL_BYTE, 1'b1, link_channel_reg);
                        phase_next = PH_WEL_DATA;
                    end
                    PH_WEL_DATA:
                    begin
                        push_cnt = 2'd1;
                        if (!request.link_byte[WEL_BIT])
                        begin
                            res0       = done_res(STATUS_WEL_FAIL);
                            phase_next = PH_IDLE;
                        end
                        else if (operation_reg == OP_PROGRAM)
                        begin
                            // The chunk ends at the page boundary or at the last byte.
                            page_left_next = (bytes_left_reg < LEN_W'(room))
                                           ? PAGE_CNT_W'(bytes_left_reg) : room;
                            res0       = frame_res(program_op_reg, 1'b0, link_channel_reg);
                            phase_next = PH_OPCODE;
                        end
                        else
                        begin
                            res0       = frame_res(erase_op_reg, 1'b0, link_channel_reg);
                            phase_next = PH_OPCODE;
                        end
                    end
                    PH_OPCODE:
                    begin
                        push_cnt      = 2'd1;
                        addr_idx_next = 2'd0;
                        res0          = frame_res(link_addr[23:16], 1'b0, link_channel_reg);
                        phase_next    = PH_ADDR;
                    end
                    PH_ADDR:
                    begin
                        push_cnt = 2'd1;
                        if (addr_idx_reg < 2'd2)
                        begin
                            addr_idx_next = idx_inc;
                            res0 = frame_res(addr_byte_next,
                                             (operation_reg == OP_ERASE) && (idx_inc == 2'd2),
                                             link_channel_reg);
                        end
                        else if (operation_reg == OP_READ)
                        begin
                            // The dummy byte repeats the low address byte.
                            res0       = frame_res(link_addr[7:0], 1'b0, link_channel_reg);
                            phase_next = PH_DUMMY;
                        end
                        else if (operation_reg == OP_PROGRAM)
                        begin
                            res0       = host_req_res();
                            phase_next = PH_HOST;
                        end
                        else if (cur_sector_reg == stop_sector_reg)
                        begin
                            res0       = done_res(STATUS_OK);
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            cur_sector_next = cur_sector_reg + SECTOR_W'(1);
                            res0       = frame_res(status_op_reg, 1'b0, link_channel_reg);
                            phase_next = PH_POLL_CMD;
                        end
                    end
                    PH_DUMMY:
                    begin
                        push_cnt   = 2'd1;
                        res0       = frame_res(FILL_BYTE, bytes_left_reg == LEN_W'(1),
                                               link_channel_reg);
                        phase_next = PH_RDATA;
                    end
                    PH_RDATA:
                    begin
                        push_cnt        = 2'd2;
                        bytes_left_next = bytes_dec;
                        res0            = read_res(request.link_byte);
                        if (bytes_dec == '0)
                        begin
                            res1       = done_res(STATUS_OK);
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            res1 = frame_res(FILL_BYTE, bytes_dec == LEN_W'(1),
                                             link_channel_reg);
                        end
                    end
                    PH_WDATA:
                    begin
                        push_cnt        = 2'd1;
                        bytes_left_next = bytes_dec;
                        page_left_next  = page_dec;
                        cur_addr_next   = cur_addr_reg + AW'(1);
                        if (bytes_dec == '0)
                        begin
                            res0       = done_res(STATUS_OK);
                            phase_next = PH_IDLE;
                        end
                        else if (page_dec == '0)
                        begin
                            res0       = frame_res(status_op_reg, 1'b0, link_channel_reg);
                            phase_next = PH_POLL_CMD;
                        end
                        else
                        begin
                            res0       = host_req_res();
                            phase_next = PH_HOST;
                        end
                    end
                    default:
                    begin
                        push_cnt = 2'd0;
                    end
                endcase
            end
        end

        if (push_cnt == 2'd1)
        begin
            res0.last = 1'b1;
        end
        else if (push_cnt == 2'd2)
        begin
            res1.last = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            operation_reg   <= OP_READ;
            cur_addr_reg    <= '0;
            bytes_left_reg  <= '0;
            page_left_reg   <= '0;
            cur_sector_reg  <= '0;
            stop_sector_reg <= '0;
            addr_idx_reg    <= '0;
        end
        else
        begin
            phase_reg       <= phase_next;
            operation_reg   <= operation_next;
            cur_addr_reg    <= cur_addr_next;
            bytes_left_reg  <= bytes_left_next;
            page_left_reg   <= page_left_next;
            cur_sector_reg  <= cur_sector_next;
            stop_sector_reg <= stop_sector_next;
            addr_idx_reg    <= addr_idx_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_channel_reg <= 2'd0;
            read_op_reg      <= 8'd11;
            program_op_reg   <= 8'd2;
            erase_op_reg     <= 8'd32;
            wren_op_reg      <= 8'd6;
            status_op_reg    <= 8'd5;
        end
        else if (cfg_write_enable)
        begin
            case (cfg_index)
                CFG_LINK_CHANNEL: link_channel_reg <= cfg_data[1:0];
                CFG_READ_OP:      read_op_reg      <= cfg_data;
                CFG_PROGRAM_OP:   program_op_reg   <= cfg_data;
                CFG_ERASE_OP:     erase_op_reg     <= cfg_data;
                CFG_WREN_OP:      wren_op_reg      <= cfg_data;
                CFG_STATUS_OP:    status_op_reg    <= cfg_data;
                default:          link_channel_reg <= link_channel_reg;
            endcase
        end
    end

    // Result queue control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_reg + QPTR_W'(pop);
            wr_ptr_reg <= wr_ptr_reg + QPTR_W'(push_cnt);
            count_reg  <= count_reg + QCNT_W'(push_cnt) - QCNT_W'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            queue_reg[wr_ptr_reg] <= res0;
        end
        if (push_cnt == 2'd2)
        begin
            queue_reg[wr_ptr_reg + QPTR_W'(1)] <= res1;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/sfc_checker.sv
// Port-level checker for the SPI NOR flash command sequencer, with its bind.
// Depends on sfc_pkg and spi_nor_flash_command_sequencer.
`default_nettype none

module sfc_checker
    import sfc_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    result_valid,
    input wire logic    result_stall,
    input wire result_t result
);

    // A stalled result transfer keeps its valid.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result valid dropped while stalled");

    // A stalled result transfer keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(result))
        else $error("result payload changed while stalled");

    // Only link frames carry a byte, a channel or an end-of-frame mark.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.kind != KIND_FRAME) |->
            (result.tx_byte == '0) && !result.end_of_frame && (result.channel == '0))
        else $error("frame fields set on a non-frame result");

    // Completion always ends the results of its transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.kind == KIND_DONE) |-> result.last)
        else $error("done result without last");

    // Read data is always followed by a frame or a done from the same transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.kind == KIND_READ) |-> !result.last)
        else $error("read data marked last");

endmodule

bind spi_nor_flash_command_sequencer sfc_checker u_sfc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

`default_nettype wire
